// ----- sv/btbp_pkg.sv -----
// Shared constants for the transaction boundary parser: field sizes, phases and field kinds.
`timescale 1ns / 1ps
`default_nettype none
package btbp_pkg;

  localparam logic [63:0] VERSION_BYTES   = 64'd4;
  localparam logic [63:0] OUTPOINT_BYTES  = 64'd36;
  localparam logic [63:0] SEQUENCE_BYTES  = 64'd4;
  localparam logic [63:0] VALUE_BYTES     = 64'd8;
  localparam logic [63:0] LOCK_TIME_BYTES = 64'd4;

  localparam logic [7:0] VARINT_PFX_2 = 8'hfd;
  localparam logic [7:0] VARINT_PFX_4 = 8'hfe;
  localparam logic [7:0] VARINT_PFX_8 = 8'hff;
  localparam logic [7:0] MARKER_BYTE  = 8'h00;
  localparam logic [7:0] FLAG_BYTE    = 8'h01;

  typedef logic [3:0] phase_t;
  localparam phase_t PH_VERSION    = 4'd0;
  localparam phase_t PH_MARKER     = 4'd1;
  localparam phase_t PH_FLAG       = 4'd2;
  localparam phase_t PH_IN_COUNT   = 4'd3;
  localparam phase_t PH_OUTPOINT   = 4'd4;
  localparam phase_t PH_IN_SLEN    = 4'd5;
  localparam phase_t PH_IN_SCRIPT  = 4'd6;
  localparam phase_t PH_SEQUENCE   = 4'd7;
  localparam phase_t PH_OUT_COUNT  = 4'd8;
  localparam phase_t PH_VALUE      = 4'd9;
  localparam phase_t PH_OUT_SLEN   = 4'd10;
  localparam phase_t PH_OUT_SCRIPT = 4'd11;
  localparam phase_t PH_WIT_COUNT  = 4'd12;
  localparam phase_t PH_WIT_LEN    = 4'd13;
  localparam phase_t PH_WIT_DATA   = 4'd14;
  localparam phase_t PH_LOCKTIME   = 4'd15;

  typedef logic [3:0] kind_t;
  localparam kind_t KIND_VERSION  = 4'd0;
  localparam kind_t KIND_MARKER   = 4'd1;
  localparam kind_t KIND_COUNT    = 4'd2;
  localparam kind_t KIND_OUTPOINT = 4'd3;
  localparam kind_t KIND_LENGTH   = 4'd4;
  localparam kind_t KIND_SCRIPT   = 4'd5;
  localparam kind_t KIND_SEQUENCE = 4'd6;
  localparam kind_t KIND_VALUE    = 4'd7;
  localparam kind_t KIND_WITNESS  = 4'd8;
  localparam kind_t KIND_LOCKTIME = 4'd9;

endpackage
`default_nettype wire

// ----- sv/bitcoin_tx_boundary_parser_unit.sv -----
// Transaction boundary parser: field tracking per byte, registered result per request.
//
// Input channel: one stream byte per request (data_byte, start_of_tx) on in_valid/in_stall.
// start_of_tx resynchronises: the byte is taken as the first version byte.
// Output channel: one result per input request (tx_end, field_kind, is_segwit) on
// out_valid/out_stall, in request order.
// Latency: the result is presented in the cycle after the request is taken.
// Throughput: one byte per clock while in_stall is low; the parse state is updated in the same cycle the byte is
// taken, through a single level of varint decode and 64-bit count-down logic.
// in_stall is raised only while a result waits in the output register and out_stall is high;
// when the receiver takes the result, a new request can be taken in the same cycle.
// cfg_write_en writes segwit_enable (reset value 1); write it while the block is idle.
// Reset (rst, synchronous) empties the output register and returns the parser to the
// start of a version field with all counts cleared.
`timescale 1ns / 1ps
`default_nettype none
module bitcoin_tx_boundary_parser_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_write_en,
  input  wire               cfg_write_data,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [7:0]        data_byte,
  input  wire               start_of_tx,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              tx_end,
  output btbp_pkg::kind_t   field_kind,
  output logic              is_segwit
);
  import btbp_pkg::*;

  logic        segwit_enable;
  phase_t      phase, phase_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [63:0] varint_value, varint_value_next;
  logic [3:0]  varint_bytes_left, varint_bytes_left_next;
  logic [2:0]  varint_pos, varint_pos_next;
  logic [63:0] input_count_saved, input_count_saved_next;
  logic [63:0] input_count_left, input_count_left_next;
  logic [63:0] output_count_left, output_count_left_next;
  logic [63:0] witness_items_left, witness_items_left_next;
  logic        segwit_seen, segwit_seen_next;

  phase_t      ph_e, disp;
  logic [63:0] bl_e, vv_e, bl_dec, oc_dec, icl_dec, wi_dec;
  logic [3:0]  vl_e;
  logic [2:0]  vp_e;
  logic        seen_e, vdone, wit_after_outs, end_now;
  logic [63:0] vv_n;
  logic [3:0]  vl_n;
  logic [2:0]  vp_n;
  kind_t       kind;
  logic        accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // resync view of the state
    ph_e   = start_of_tx ? PH_VERSION    : phase;
    bl_e   = start_of_tx ? VERSION_BYTES : bytes_left;
    vv_e   = start_of_tx ? 64'd0         : varint_value;
    vl_e   = start_of_tx ? 4'd0          : varint_bytes_left;
    vp_e   = start_of_tx ? 3'd0          : varint_pos;
    seen_e = start_of_tx ? 1'b0          : segwit_seen;

    bl_dec  = bl_e - 64'd1;
    oc_dec  = output_count_left - 64'd1;
    icl_dec = input_count_left - 64'd1;
    wi_dec  = witness_items_left - 64'd1;

    // varint byte
    if (vl_e == 4'd0) begin
      vp_n = 3'd0;
      if (data_byte == VARINT_PFX_8) begin
        vv_n = 64'd0; vl_n = 4'd8; vdone = 1'b0;
      end else if (data_byte == VARINT_PFX_4) begin
        vv_n = 64'd0; vl_n = 4'd4; vdone = 1'b0;
      end else if (data_byte == VARINT_PFX_2) begin
        vv_n = 64'd0; vl_n = 4'd2; vdone = 1'b0;
      end else begin
        vv_n = {56'd0, data_byte}; vl_n = 4'd0; vdone = 1'b1;
      end
    end else begin
      vv_n  = vv_e | ({56'd0, data_byte} << {vp_e, 3'b000});
      vp_n  = vp_e + 3'd1;
      vl_n  = vl_e - 4'd1;
      vdone = (vl_e == 4'd1);
    end

    phase_next              = ph_e;
    bytes_left_next         = bl_e;
    varint_value_next       = vv_e;
    varint_bytes_left_next  = vl_e;
    varint_pos_next         = vp_e;
    input_count_saved_next  = input_count_saved;
    input_count_left_next   = input_count_left;
    output_count_left_next  = output_count_left;
    witness_items_left_next = witness_items_left;
    segwit_seen_next        = seen_e;
    end_now                 = 1'b0;
    kind                    = KIND_LOCKTIME;

    // marker not taken -> input count; flag not taken -> zero inputs, output count
    disp = ph_e;
    if (ph_e == PH_MARKER && !(segwit_enable && data_byte == MARKER_BYTE)) begin
      disp = PH_IN_COUNT;
      phase_next = PH_IN_COUNT;
    end else if (ph_e == PH_FLAG && data_byte != FLAG_BYTE) begin
      disp = PH_OUT_COUNT;
      phase_next = PH_OUT_COUNT;
      input_count_saved_next = 64'd0;
      input_count_left_next  = 64'd0;
    end

    wit_after_outs = seen_e && (input_count_saved_next != 64'd0);

    case (disp)
      PH_VERSION: begin
        kind = KIND_VERSION;
        bytes_left_next = bl_dec;
        if (bl_dec == 64'd0) phase_next = segwit_enable ? PH_MARKER : PH_IN_COUNT;
      end
      PH_MARKER: begin
        kind = KIND_MARKER;
        phase_next = PH_FLAG;
      end
      PH_FLAG: begin
        kind = KIND_MARKER;
        segwit_seen_next = 1'b1;
        phase_next = PH_IN_COUNT;
      end
      PH_IN_COUNT: begin
        kind = KIND_COUNT;
        varint_value_next = vv_n; varint_bytes_left_next = vl_n; varint_pos_next = vp_n;
        if (vdone) begin
          input_count_saved_next = vv_n;
          input_count_left_next  = vv_n;
          if (vv_n == 64'd0) begin
            phase_next = PH_OUT_COUNT;
          end else begin
            phase_next = PH_OUTPOINT; bytes_left_next = OUTPOINT_BYTES;
          end
        end
      end
      PH_OUTPOINT: begin
        kind = KIND_OUTPOINT;
        bytes_left_next = bl_dec;
        if (bl_dec == 64'd0) phase_next = PH_IN_SLEN;
      end
      PH_IN_SLEN: begin
        kind = KIND_LENGTH;
        varint_value_next = vv_n; varint_bytes_left_next = vl_n; varint_pos_next = vp_n;
        if (vdone) begin
          if (vv_n == 64'd0) begin
            phase_next = PH_SEQUENCE; bytes_left_next = SEQUENCE_BYTES;
          end else begin
            phase_next = PH_IN_SCRIPT; bytes_left_next = vv_n;
          end
        end
      end
      PH_IN_SCRIPT: begin
        kind = KIND_SCRIPT;
        bytes_left_next = bl_dec;
        if (bl_dec == 64'd0) begin
          phase_next = PH_SEQUENCE; bytes_left_next = SEQUENCE_BYTES;
        end
      end
      PH_SEQUENCE: begin
        kind = KIND_SEQUENCE;
        bytes_left_next = bl_dec;
        if (bl_dec == 64'd0) begin
          input_count_left_next = icl_dec;
          if (icl_dec == 64'd0) begin
            phase_next = PH_OUT_COUNT;
          end else begin
            phase_next = PH_OUTPOINT; bytes_left_next = OUTPOINT_BYTES;
          end
        end
      end
      PH_OUT_COUNT: begin
        kind = KIND_COUNT;
        varint_value_next = vv_n; varint_bytes_left_next = vl_n; varint_pos_next = vp_n;
        if (vdone) begin
          output_count_left_next = vv_n;
          if (vv_n != 64'd0) begin
            phase_next = PH_VALUE; bytes_left_next = VALUE_BYTES;
          end else if (wit_after_outs) begin
            input_count_left_next = input_count_saved_next; phase_next = PH_WIT_COUNT;
          end else begin
            phase_next = PH_LOCKTIME; bytes_left_next = LOCK_TIME_BYTES;
          end
        end
      end
      PH_VALUE: begin
        kind = KIND_VALUE;
        bytes_left_next = bl_dec;
        if (bl_dec == 64'd0) phase_next = PH_OUT_SLEN;
      end
      PH_OUT_SLEN, PH_OUT_SCRIPT: begin
        if (disp == PH_OUT_SLEN) begin
          kind = KIND_LENGTH;
          varint_value_next = vv_n; varint_bytes_left_next = vl_n; varint_pos_next = vp_n;
        end else begin
          kind = KIND_SCRIPT;
          bytes_left_next = bl_dec;
        end
        if ((disp == PH_OUT_SLEN && vdone && vv_n != 64'd0)) begin
          phase_next = PH_OUT_SCRIPT; bytes_left_next = vv_n;
        end else if ((disp == PH_OUT_SLEN && vdone) ||
                     (disp == PH_OUT_SCRIPT && bl_dec == 64'd0)) begin
          // output finished
          output_count_left_next = oc_dec;
          if (oc_dec != 64'd0) begin
            phase_next = PH_VALUE; bytes_left_next = VALUE_BYTES;
          end else if (wit_after_outs) begin
            input_count_left_next = input_count_saved_next; phase_next = PH_WIT_COUNT;
          end else begin
            phase_next = PH_LOCKTIME; bytes_left_next = LOCK_TIME_BYTES;
          end
        end
      end
      PH_WIT_COUNT: begin
        kind = KIND_COUNT;
        varint_value_next = vv_n; varint_bytes_left_next = vl_n; varint_pos_next = vp_n;
        if (vdone) begin
          witness_items_left_next = vv_n;
          if (vv_n != 64'd0) begin
            phase_next = PH_WIT_LEN;
          end else begin
            input_count_left_next = icl_dec;
            if (icl_dec == 64'd0) begin
              phase_next = PH_LOCKTIME; bytes_left_next = LOCK_TIME_BYTES;
            end else begin
              phase_next = PH_WIT_COUNT;
            end
          end
        end
      end
      PH_WIT_LEN, PH_WIT_DATA: begin
        if (disp == PH_WIT_LEN) begin
          kind = KIND_LENGTH;
          varint_value_next = vv_n; varint_bytes_left_next = vl_n; varint_pos_next = vp_n;
        end else begin
          kind = KIND_WITNESS;
          bytes_left_next = bl_dec;
        end
        if (disp == PH_WIT_LEN && vdone && vv_n != 64'd0) begin
          phase_next = PH_WIT_DATA; bytes_left_next = vv_n;
        end else if ((disp == PH_WIT_LEN && vdone) ||
                     (disp == PH_WIT_DATA && bl_dec == 64'd0)) begin
          // witness item finished
          witness_items_left_next = wi_dec;
          if (wi_dec != 64'd0) begin
            phase_next = PH_WIT_LEN;
          end else begin
            input_count_left_next = icl_dec;
            if (icl_dec == 64'd0) begin
              phase_next = PH_LOCKTIME; bytes_left_next = LOCK_TIME_BYTES;
            end else begin
              phase_next = PH_WIT_COUNT;
            end
          end
        end
      end
      default: begin
        // lock time
        kind = KIND_LOCKTIME;
        bytes_left_next = bl_dec;
        if (bl_dec == 64'd0) end_now = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segwit_enable      <= 1'b1;
      phase              <= PH_VERSION;
      bytes_left         <= VERSION_BYTES;
      varint_value       <= 64'd0;
      varint_bytes_left  <= 4'd0;
      varint_pos         <= 3'd0;
      input_count_saved  <= 64'd0;
      input_count_left   <= 64'd0;
      output_count_left  <= 64'd0;
      witness_items_left <= 64'd0;
      segwit_seen        <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write_en) segwit_enable <= cfg_write_data;
      if (accept) begin
        input_count_saved  <= input_count_saved_next;
        input_count_left   <= input_count_left_next;
        output_count_left  <= output_count_left_next;
        witness_items_left <= witness_items_left_next;
        if (end_now) begin
          phase             <= PH_VERSION;
          bytes_left        <= VERSION_BYTES;
          varint_value      <= 64'd0;
          varint_bytes_left <= 4'd0;
          varint_pos        <= 3'd0;
          segwit_seen       <= 1'b0;
        end else begin
          phase             <= phase_next;
          bytes_left        <= bytes_left_next;
          varint_value      <= varint_value_next;
          varint_bytes_left <= varint_bytes_left_next;
          varint_pos        <= varint_pos_next;
          segwit_seen       <= segwit_seen_next;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_end     <= end_now;
      field_kind <= kind;
      is_segwit  <= segwit_seen_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/btbp_checker.sv -----
// Port-level checks for the transaction boundary parser, bound to bitcoin_tx_boundary_parser_unit.
`timescale 1ns / 1ps
`default_nettype none
module btbp_checker (
  input wire              clk,
  input wire              rst,
  input wire              in_valid,
  input wire              in_stall,
  input wire              out_valid,
  input wire              out_stall,
  input wire              tx_end,
  input btbp_pkg::kind_t  field_kind,
  input wire              is_segwit
);
  import btbp_pkg::*;

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_kind) && $stable(tx_end)
      && $stable(is_segwit))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_req_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("request produced no result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> field_kind <= KIND_LOCKTIME)
    else $error("field kind out of range");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_end |-> field_kind == KIND_LOCKTIME)
    else $error("end flagged outside lock time");

endmodule

bind bitcoin_tx_boundary_parser_unit btbp_checker u_btbp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tx_end     (tx_end),
  .field_kind (field_kind),
  .is_segwit  (is_segwit)
);
`default_nettype wire
